@@ sv/dtf_pkg.sv @@
// ----------------------------------------------------------------------------
// dtf_pkg: shared constants and types for decimal text to fixed point
// Field widths, character codes and the fraction digit weight table.
// ----------------------------------------------------------------------------
`default_nettype none

package dtf_pkg;

  localparam int INT_BITS        = 31;
  localparam int FRAC_BITS       = 32;
  localparam int MAX_FRAC_DIGITS = 9;

  localparam int CHAR_W     = 8;
  localparam int VALUE_W    = 64;
  localparam int DIGIT_W    = 4;
  localparam int FRAC_CNT_W = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int WEIGHT_N   = 9;

  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [INT_BITS-1:0]   int_t;
  typedef logic [FRAC_BITS-1:0]  frac_t;
  typedef logic [DIGIT_W-1:0]    digit_t;
  typedef logic [FRAC_CNT_W-1:0] frac_cnt_t;

  localparam int_t  INT_MAX  = '1;
  localparam frac_t FRAC_MAX = '1;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;

  localparam logic [63:0] FRAC_ONE = 64'd1 << FRAC_BITS;

  // Entry i holds 2^FRAC_BITS / 10^(i+1), rounded half up
  localparam frac_t FRAC_W [WEIGHT_N] = '{
    frac_t'((FRAC_ONE + 64'd5)          / 64'd10),
    frac_t'((FRAC_ONE + 64'd50)         / 64'd100),
    frac_t'((FRAC_ONE + 64'd500)        / 64'd1000),
    frac_t'((FRAC_ONE + 64'd5000)       / 64'd10000),
    frac_t'((FRAC_ONE + 64'd50000)      / 64'd100000),
    frac_t'((FRAC_ONE + 64'd500000)     / 64'd1000000),
    frac_t'((FRAC_ONE + 64'd5000000)    / 64'd10000000),
    frac_t'((FRAC_ONE + 64'd50000000)   / 64'd100000000),
    frac_t'((FRAC_ONE + 64'd500000000)  / 64'd1000000000)
  };

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               overflow;
  } result_t;

endpackage

`default_nettype wire

@@ sv/dtf_parse.sv @@
// ----------------------------------------------------------------------------
// dtf_parse: per-character parse state and update
// Holds the accumulators and flags; computes the result for a terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module dtf_parse
  import dtf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step,
  input  wire char_t char_in,
  output result_t    res
);

  int_t      int_accum,   int_accum_next;
  frac_t     frac_accum,  frac_accum_next;
  frac_cnt_t frac_count,  frac_count_next;
  logic      is_negative, is_negative_next;
  logic      in_fraction, in_fraction_next;
  logic      at_start,    at_start_next;
  logic      stopped,     stopped_next;
  logic      sat_flag,    sat_flag_next;

  logic                   is_digit;
  digit_t                 digit;
  char_t                  char_off;
  logic [INT_BITS+3:0]    int_wide;
  logic [FRAC_BITS+3:0]   frac_add;
  logic [FRAC_BITS+4:0]   frac_sum;
  logic [VALUE_W-1:0]     mag;

  assign char_off = char_in - CH_ZERO;
  assign digit    = char_off[DIGIT_W-1:0];
  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);

  // x10 as two shifts and an add
  assign int_wide = ((INT_BITS+4)'(int_accum) << 3) + ((INT_BITS+4)'(int_accum) << 1)
                  + (INT_BITS+4)'(digit);
  assign frac_add = (FRAC_BITS+4)'(FRAC_W[frac_count]) * (FRAC_BITS+4)'(digit);
  assign frac_sum = (FRAC_BITS+5)'(frac_accum) + (FRAC_BITS+5)'(frac_add);

  assign mag          = VALUE_W'({int_accum, frac_accum});
  assign res.value    = is_negative ? (VALUE_W'(0) - mag) : mag;
  assign res.overflow = sat_flag;

  always_comb begin
    int_accum_next   = int_accum;
    frac_accum_next  = frac_accum;
    frac_count_next  = frac_count;
    is_negative_next = is_negative;
    in_fraction_next = in_fraction;
    at_start_next    = at_start;
    stopped_next     = stopped;
    sat_flag_next    = sat_flag;
    if (char_in == CH_NUL) begin
      int_accum_next   = '0;
      frac_accum_next  = '0;
      frac_count_next  = '0;
      is_negative_next = 1'b0;
      in_fraction_next = 1'b0;
      at_start_next    = 1'b1;
      stopped_next     = 1'b0;
      sat_flag_next    = 1'b0;
    end else if (!stopped) begin
      at_start_next = 1'b0;
      if (at_start && char_in == CH_MINUS) begin
        is_negative_next = 1'b1;
      end else if (at_start && char_in == CH_PLUS) begin
        is_negative_next = is_negative;
      end else if (char_in == CH_DOT) begin
        if (in_fraction) begin
          stopped_next = 1'b1;
        end else begin
          in_fraction_next = 1'b1;
        end
      end else if (is_digit) begin
        if (!in_fraction) begin
          if (int_wide > (INT_BITS+4)'(INT_MAX)) begin
            int_accum_next = INT_MAX;
            sat_flag_next  = 1'b1;
          end else begin
            int_accum_next = int_wide[INT_BITS-1:0];
          end
        end else if (frac_count < FRAC_CNT_W'(MAX_FRAC_DIGITS)) begin
          frac_count_next = frac_count + 1'b1;
          if (frac_sum > (FRAC_BITS+5)'(FRAC_MAX)) begin
            frac_accum_next = FRAC_MAX;
          end else begin
            frac_accum_next = frac_sum[FRAC_BITS-1:0];
          end
        end
      end else begin
        stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_accum   <= '0;
      frac_accum  <= '0;
      frac_count  <= '0;
      is_negative <= 1'b0;
      in_fraction <= 1'b0;
      at_start    <= 1'b1;
      stopped     <= 1'b0;
      sat_flag    <= 1'b0;
    end else if (step) begin
      int_accum   <= int_accum_next;
      frac_accum  <= frac_accum_next;
      frac_count  <= frac_count_next;
      is_negative <= is_negative_next;
      in_fraction <= in_fraction_next;
      at_start    <= at_start_next;
      stopped     <= stopped_next;
      sat_flag    <= sat_flag_next;
    end
  end

  a_sat_pins_max: assert property (@(posedge clk) disable iff (rst)
    sat_flag |-> int_accum == INT_MAX)
    else $error("saturation flag set with integer part below maximum");

  a_frac_needs_dot: assert property (@(posedge clk) disable iff (rst)
    frac_count != '0 |-> in_fraction)
    else $error("fraction digits counted outside fraction part");

  a_stop_after_start: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !at_start)
    else $error("parse stopped with no character taken");

endmodule

`default_nettype wire

@@ sv/dtf_out_reg.sv @@
// ----------------------------------------------------------------------------
// dtf_out_reg: result register for the master side
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtf_out_reg
  import dtf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire result_t      res,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [VALUE_W-1:0] m_axis_tdata,   // [63:0] value
  output logic              m_axis_tuser     // [0] overflow
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= res.value;
      m_axis_tuser <= res.overflow;
    end
  end

endmodule

`default_nettype wire

@@ sv/decimal_text_to_fixed.sv @@
// ----------------------------------------------------------------------------
// decimal_text_to_fixed: decimal text to signed Q31.32
// Parses a zero-terminated ASCII decimal string, one character a request.
// ----------------------------------------------------------------------------
// Slave side: one ASCII character per request on s_axis_tdata[7:0]. A zero
// byte ends the string. Only the zero byte yields a result; every other
// character just updates the parse state.
// Master side: m_axis_tdata carries the signed Q31.32 value, m_axis_tuser
// the overflow flag (integer part saturated).
// Throughput: one character per cycle, sustained while no zero byte waits
// for a full result register; the digit update is a single x10 add or
// weight multiply-add between the input register and the parse state.
// A zero byte passes the input register, then its result is loaded into
// the result register.
// Reset clears the valid flags of both registers and returns the parser to the start of a
// string. When the receiver stalls, the result is held and characters keep
// flowing until a second zero byte reaches the input register; that one
// waits there until the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_fixed
  import dtf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,   // [7:0] char_in
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [VALUE_W-1:0] m_axis_tdata,   // [63:0] value
  output logic               m_axis_tuser    // [0] overflow
);

  logic    in_valid;
  char_t   in_char;
  logic    is_term;
  logic    out_free;
  logic    advance;
  result_t res;

  assign is_term       = (in_char == CH_NUL);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && (!is_term || out_free);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_char <= s_axis_tdata;
    end
  end

  dtf_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .char_in (in_char),
    .res     (res)
  );

  dtf_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance && is_term),
    .res           (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !in_valid)
    else $error("valid left high after reset");

  a_result_from_term: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(m_axis_tvalid) |-> $past(in_valid && is_term))
    else $error("result appeared without a terminator");

  a_term_waits: assert property (@(posedge clk) disable iff (rst)
    in_valid && is_term && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("terminator dropped while result stalled");

endmodule

`default_nettype wire
